// File: rtl/integer_to_ascii_radix_top_assert.svh
// assertion macros for the integer to ascii radix block
// used by the port checker; needs nothing else
`ifndef INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define ITOA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/itoa_pkg.sv
// shared constants, types and helpers of the integer to ascii radix block
// no dependencies
`default_nettype none

package itoa_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAX_DIGITS = 32;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int REQ_DATA_W = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] DIGIT_TOP  = 6'd9;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [RADIX_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [RADIX_W-1:0]    remainder;
   } div_rsp_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d > DIGIT_TOP) begin
         c = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_TOP) - CHAR_W'(1);
      end else begin
         c = CHAR_ZERO + CHAR_W'(d);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/itoa_div.sv
// restoring divider, one quotient bit per cycle, by a small radix
// depends on itoa_pkg
`default_nettype none

module itoa_div (
   input  wire                        clock,
   input  wire                        reset,
   input  itoa_pkg::div_req_type      req,
   output itoa_pkg::div_rsp_type      rsp
);
   import itoa_pkg::*;

   localparam int BIT_W = $clog2(VALUE_BITS);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type             state_ff, state_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    div_ff, div_in;
   logic                  done_ff, done_in;
   logic [RADIX_W:0]      rem_shift;
   logic                  fits;

   // shift in the next dividend bit, subtract when it fits
   assign rem_shift = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               quo_in   = req.dividend;
               rem_in   = '0;
               div_in   = req.divisor;
               bit_in   = BIT_W'(VALUE_BITS - 1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            quo_in = {quo_ff[VALUE_BITS-2:0], fits};
            rem_in = fits ? RADIX_W'(rem_shift - {1'b0, div_ff}) : rem_shift[RADIX_W-1:0];
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_radix_top.sv
// integer to ascii conversion in radix 2..36, sequencer and digit store
// depends on itoa_pkg and itoa_div
//
//  channel   dir  ports                   payload
//  req       in   req_tvalid/tready/tdata value[31:0], radix[37:32]
//  rsp       out  rsp_tvalid/tready/tdata char_code[7:0], tlast = last_char
//
// a word is converted one digit at a time: each digit is a start, 32 quotient
// bits in the shared divider and a write-back to the digit store; once all
// digits are stored, a leading minus is sent first, then each char is a
// store read followed by a send.
// req_tready is high only when idle; rsp stalls simply hold the sequencer.
// synchronous reset returns to idle; the digit store needs no clearing.
`default_nettype none

module integer_to_ascii_radix_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [itoa_pkg::REQ_DATA_W-1:0]     req_tdata,  // value, radix, zero pad
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_tdata,  // char_code
   output logic                                rsp_tlast
);
   import itoa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MINUS,
      ST_READ,
      ST_SEND
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic                  minus_ff, minus_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RADIX_W-1:0]    rd_data_ff;
   logic [RADIX_W-1:0]    digit_store [MAX_DIGITS];

   logic [VALUE_BITS-1:0] in_value;
   logic [RADIX_W-1:0]    in_radix;
   logic [RADIX_W-1:0]    radix_clamp;
   logic                  in_neg;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   assign in_value = req_tdata[VALUE_BITS-1:0];
   assign in_radix = req_tdata[VALUE_BITS+RADIX_W-1:VALUE_BITS];
   assign in_neg   = in_value[VALUE_BITS-1];

   always_comb begin
      radix_clamp = in_radix;
      if (in_radix < RADIX_MIN) begin
         radix_clamp = RADIX_MIN;
      end else if (in_radix > RADIX_MAX) begin
         radix_clamp = RADIX_MAX;
      end
   end

   assign div_req.start    = state_ff == ST_DIV_START;
   assign div_req.dividend = mag_ff;
   assign div_req.divisor  = radix_ff;

   itoa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      radix_in = radix_ff;
      minus_in = minus_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               radix_in = radix_clamp;
               minus_in = (radix_clamp == RADIX_DEC) && in_neg;
               // minimum integer negates to itself, read as unsigned 2^31
               mag_in   = ((radix_clamp == RADIX_DEC) && in_neg) ? (~in_value + 1'b1)
                                                                 : in_value;
               cnt_in   = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               mag_in = div_rsp.quotient;
               cnt_in = cnt_ff + CNT_W'(1);
               if ((div_rsp.quotient == '0) || (cnt_in == CNT_W'(MAX_DIGITS))) begin
                  state_in = minus_ff ? ST_MINUS : ST_READ;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_MINUS: begin
            if (rsp_tready) begin
               minus_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_tready) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         minus_ff <= 1'b0;
         cnt_ff   <= '0;
         mag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         minus_ff <= minus_in;
         cnt_ff   <= cnt_in;
         mag_ff   <= mag_in;
      end
      radix_ff <= radix_in;
   end

   // digit store, least significant digit at entry zero
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_WAIT) && div_rsp.done) begin
         digit_store[cnt_ff[IDX_W-1:0]] <= div_rsp.remainder;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= digit_store[IDX_W'(cnt_ff - CNT_W'(1))];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = (state_ff == ST_MINUS) || (state_ff == ST_SEND);
   assign rsp_tdata  = (state_ff == ST_MINUS) ? CHAR_MINUS : digit_char(rd_data_ff);
   assign rsp_tlast  = (state_ff == ST_SEND) && (cnt_ff == CNT_W'(1));

endmodule

`default_nettype wire

// File: rtl/itoa_port_check.sv
// port-level checker for the integer to ascii radix block, with its bind
// depends on itoa_pkg and integer_to_ascii_radix_top_assert.svh
`default_nettype none
`include "integer_to_ascii_radix_top_assert.svh"

module itoa_port_check (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tvalid,
   input wire                          req_tready,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire [itoa_pkg::CHAR_W-1:0]   rsp_tdata,
   input wire                          rsp_tlast
);
   import itoa_pkg::*;

   logic is_digit;
   logic is_letter;
   logic is_minus;

   assign is_digit  = (rsp_tdata >= CHAR_ZERO) && (rsp_tdata <= CHAR_ZERO + 8'd9);
   assign is_letter = (rsp_tdata >= CHAR_A) && (rsp_tdata <= CHAR_A + 8'd25);
   assign is_minus  = rsp_tdata == CHAR_MINUS;

   // a char waiting to be taken stays
   `ITOA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")
   // one number at a time: no new word while chars are out
   `ITOA_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "req ready while rsp pending")
   `ITOA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after accept")
   `ITOA_ASSERT_NOW(a_char_set, clock, reset, rsp_tvalid, is_digit || is_letter || is_minus, "rsp char outside digit set")
   // the sign always precedes at least one digit
   `ITOA_ASSERT_NOW(a_minus_not_last, clock, reset, rsp_tvalid && is_minus, !rsp_tlast, "minus marked last")

endmodule

bind integer_to_ascii_radix_top itoa_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: dv/tb_integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
// testbench for integer_to_ascii_radix_top: directed and random numbers in every radix,
// character stream checked against a scoreboard that spells each number itself
// depends on itoa_pkg and the block's rtl

module tb_integer_to_ascii_radix_top;
   import itoa_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RANDOM_WORDS = 388;
   localparam int QUIET_LIMIT  = 8000;
   localparam int TAIL_CYCLES  = 300;
   localparam int IDLE_PCT     = 21;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_item_type;

   class itoa_checker;
      char_item_type pending_chars[$];
      int unsigned words_in;
      int unsigned chars_out;
      int unsigned minus_words;
      int unsigned faults;

      // spell one number the way the block should and queue its characters
      function void note_word(input logic [VALUE_BITS-1:0] value,
                              input logic [RADIX_W-1:0] radix);
         int unsigned        base;
         logic [VALUE_BITS-1:0] mag;
         logic [RADIX_W-1:0] digits[$];
         char_item_type      item;
         base = 32'(radix);
         if (base < 32'(RADIX_MIN)) base = 32'(RADIX_MIN);
         if (base > 32'(RADIX_MAX)) base = 32'(RADIX_MAX);
         if (base == 32'(RADIX_DEC) && value[VALUE_BITS-1]) begin
            mag = -value;
            item.code = CHAR_MINUS;
            item.last = 1'b0;
            pending_chars.push_back(item);
            minus_words++;
         end else begin
            mag = value;
         end
         do begin
            digits.push_front(RADIX_W'(mag % base));
            mag = mag / base;
         end while (mag != 0 && digits.size() < MAX_DIGITS);
         foreach (digits[i]) begin
            if (digits[i] > DIGIT_TOP) begin
               item.code = CHAR_A + CHAR_W'(digits[i]) - 8'd10;
            end else begin
               item.code = CHAR_ZERO + CHAR_W'(digits[i]);
            end
            item.last = (i == digits.size() - 1);
            pending_chars.push_back(item);
         end
         words_in++;
      endfunction

      function void check_char(input logic [CHAR_W-1:0] code, input logic last);
         char_item_type want;
         chars_out++;
         if (pending_chars.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: unexpected char 0x%02h last %0b", $time, code, last);
            return;
         end
         want = pending_chars.pop_front();
         if (code !== want.code || last !== want.last) begin
            faults++;
            if (faults <= 10)
               $display("%0t: char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                        $time, want.code, want.last, code, last);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // value[31:0], radix[37:32], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CHAR_W-1:0]     rsp_tdata;        // char_code[7:0]
   logic                  rsp_tlast;

   bit          steady_run = 1'b0;
   int unsigned quiet_cycles = 0;
   itoa_checker sb = new();

   integer_to_ascii_radix_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready = steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_char(rsp_tdata, rsp_tlast);
   end

   // ends the run if neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("integer_to_ascii_radix_top test failed");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [VALUE_BITS-1:0] value,
                            input logic [RADIX_W-1:0] radix);
      @(negedge clock);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, radix, value};
      do @(posedge clock); while (!req_tready);
      sb.note_word(value, radix);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 9: v = $urandom;
         3, 4:       v = $urandom_range(0, 1000);
         5:          v = -$urandom_range(1, 100000);
         6:          v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
         7:          v = $urandom >> $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7fff_ffff;
               2:       v = 32'hffff_ffff;
               default: v = '0;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      logic [RADIX_W-1:0] r;
      case ($urandom_range(0, 19))
         14, 15, 16: r = RADIX_DEC;
         17:         r = RADIX_W'($urandom_range(0, 1));
         18:         r = RADIX_W'($urandom_range(37, 63));
         19:         r = 6'd16;
         default:    r = RADIX_W'($urandom_range(2, 36));
      endcase
      return r;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero, extremes, minus handling, letters and radix clamping
      send_word(32'd0, 6'd10);
      send_word(32'd0, 6'd2);
      send_word(32'h8000_0000, 6'd10);
      send_word(32'h8000_0000, 6'd2);
      send_word(32'h8000_0000, 6'd16);
      send_word(32'hffff_ffff, 6'd10);
      send_word(32'hffff_ffff, 6'd2);
      send_word(32'hffff_ffff, 6'd36);
      send_word(32'h7fff_ffff, 6'd10);
      send_word(32'h7fff_ffff, 6'd36);
      send_word(32'd35, 6'd36);
      send_word(32'd36, 6'd36);
      send_word(32'd9, 6'd10);
      send_word(32'd10, 6'd10);
      send_word(-32'sd12345, 6'd10);
      send_word(-32'sd255, 6'd16);
      send_word(32'd123456789, 6'd7);
      send_word(32'd15, 6'd16);
      send_word(32'd5, 6'd0);
      send_word(32'd5, 6'd1);
      send_word(32'd1295, 6'd37);
      send_word(32'hdead_beef, 6'd63);
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady_run = (n >= 150 && n < 230);
         if (n == 300) drain_results();
         send_word(pick_value(), pick_radix());
      end
      steady_run = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("converted %0d numbers into %0d characters, %0d with a leading minus",
               sb.words_in, sb.chars_out, sb.minus_words);
      $display("radixes 0 to 63 driven, clamped ones included; %0d faults",
               sb.faults + sb.pending_chars.size());
      if (sb.faults == 0 && sb.pending_chars.size() == 0) begin
         $display("integer_to_ascii_radix_top test passed");
      end else begin
         $display("integer_to_ascii_radix_top test failed");
      end
      $finish;
   end

endmodule
